>>> sv/sacrr_pkg.sv
package sacrr_pkg;

  // Default geometry of the cache.
  localparam int unsigned DEF_NUM_LINES = 256;
  localparam int unsigned DEF_NUM_WAYS  = 4;

  // Fixed field widths.
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned VICTIM_W    = 2;
  localparam int unsigned OFFSET_BITS = 6;

  // Access codes carried on the func field.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CMP,
    ST_RESP
  } state_t;

  // Reduces a victim code to a way number by repeated subtraction.
  // The code is at most three, so three steps always suffice.
  function automatic logic [VICTIM_W-1:0] victim_mod(input logic [VICTIM_W-1:0] v,
                                                     input int unsigned ways);
    logic [VICTIM_W-1:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (int'(r) >= int'(ways)) begin
        r = VICTIM_W'(int'(r) - int'(ways));
      end
    end
    return r;
  endfunction

endpackage

>>> sv/set_assoc_cache_random_replace.sv
// With a power-of-two set count the set and tag come straight from the address, and the ways
// are probed in order, each with a read step and a compare step, through one memory read port.
// With any other set count the line number is first split by reciprocal multiplication, one
// 16-bit digit at a time over four digits. A stalled output holds the result.
// Throughput: one access at a time; the next is taken the cycle after the result is registered.
// Reset (rst_n low, synchronous) clears all valid bits at once; no clearing pass follows.
module set_assoc_cache_random_replace #(
  parameter int unsigned NUM_LINES = sacrr_pkg::DEF_NUM_LINES,
  parameter int unsigned NUM_WAYS  = sacrr_pkg::DEF_NUM_WAYS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [sacrr_pkg::ADDR_W-1:0]    in_addr,
  input  logic [sacrr_pkg::DATA_W-1:0]    in_write_value,
  input  logic [sacrr_pkg::VICTIM_W-1:0]  in_victim_way,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [sacrr_pkg::BYTE_W-1:0]    out_read_byte
);

  // Geometry derived from the parameters.
  localparam int unsigned NUM_SETS    = (NUM_LINES / NUM_WAYS) > 0 ? (NUM_LINES / NUM_WAYS) : 1;
  localparam int unsigned STORE_DEPTH = NUM_SETS * NUM_WAYS;
  localparam bit          SETS_POW2   = (NUM_SETS & (NUM_SETS - 1)) == 0;
  localparam int unsigned SET_BITS    = $clog2(NUM_SETS);
  localparam int unsigned SET_W       = SET_BITS > 0 ? SET_BITS : 1;
  localparam int unsigned WAY_W       = $clog2(NUM_WAYS) > 0 ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned SLOT_W      = $clog2(STORE_DEPTH) > 0 ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LINE_W      = sacrr_pkg::ADDR_W - sacrr_pkg::OFFSET_BITS;
  localparam int unsigned TAG_W       = LINE_W - ($clog2(NUM_SETS + 1) - 1);
  localparam int unsigned ENT_W       = TAG_W + sacrr_pkg::DATA_W;

  // Digit division of the line number: x = {remainder, digit} < 2^X_W, and
  // floor(x * MAGIC / 2^MAG_S) is the exact quotient digit.
  localparam int unsigned DIG_W       = 16;
  localparam int unsigned DIGITS      = (LINE_W + DIG_W - 1) / DIG_W;
  localparam int unsigned NUM_W       = DIGITS * DIG_W;
  localparam int unsigned X_W         = SET_W + DIG_W;
  localparam int unsigned MAG_S       = X_W + SET_BITS;
  localparam int unsigned MAG_W       = X_W + 2;
  localparam int unsigned PROD_W      = X_W + MAG_W;
  localparam logic [MAG_W-1:0] MAGIC  =
    MAG_W'(((64'd1 << MAG_S) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));
  localparam int unsigned CNT_W       = $clog2(2 * DIGITS);

  sacrr_pkg::state_t state_r, state_nxt;

  // Access registers.
  logic                                func_r, func_nxt;
  logic [NUM_W-1:0]                    line_r, line_nxt;
  logic [sacrr_pkg::OFFSET_BITS-1:0]   offset_r, offset_nxt;
  logic [sacrr_pkg::DATA_W-1:0]        value_r, value_nxt;
  logic [WAY_W-1:0]                    victim_r, victim_nxt;
  logic [SET_W-1:0]                    set_r, set_nxt;
  logic [TAG_W-1:0]                    tag_r, tag_nxt;
  logic [WAY_W-1:0]                    way_r, way_nxt;
  logic [SET_W-1:0]                    rem_r, rem_nxt;
  logic [DIG_W-1:0]                    qd_r, qd_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic                                res_hit_r, res_hit_nxt;
  logic [sacrr_pkg::BYTE_W-1:0]        res_byte_r, res_byte_nxt;

  // Output register.
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_hit_r, out_hit_nxt;
  logic [sacrr_pkg::BYTE_W-1:0]        out_byte_r, out_byte_nxt;

  // Line store and valid bits.
  logic [ENT_W-1:0]                    mem [STORE_DEPTH];
  logic [ENT_W-1:0]                    mem_q;
  logic [STORE_DEPTH-1:0]              valid_r;
  logic                                mem_we;
  logic [SLOT_W-1:0]                   mem_waddr;
  logic [ENT_W-1:0]                    mem_wdata;

  // Datapath helpers.
  logic [SLOT_W-1:0]                   slot;
  logic [SLOT_W-1:0]                   victim_slot;
  logic [X_W-1:0]                      div_x;
  logic [PROD_W-1:0]                   div_prod;
  logic [X_W-1:0]                      div_back;
  logic [X_W-1:0]                      div_rem;
  logic [sacrr_pkg::DATA_W-1:0]        shifted;
  logic                                tag_eq;
  logic                                slot_vld;
  logic                                last_way;
  logic                                in_xfer;

  assign in_stall      = (state_r != sacrr_pkg::ST_IDLE);
  assign in_xfer       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_read_byte = out_byte_r;

  // Slot addresses of the current probe and of the victim way.
  assign slot        = SLOT_W'(set_r) * SLOT_W'(NUM_WAYS) + SLOT_W'(way_r);
  assign victim_slot = SLOT_W'(set_r) * SLOT_W'(NUM_WAYS) + SLOT_W'(victim_r);

  // One digit step of the division of the line number by the set count.
  assign div_x    = {rem_r, line_r[NUM_W-1 -: DIG_W]};
  assign div_prod = PROD_W'(div_x) * PROD_W'(MAGIC);
  assign div_back = X_W'(qd_r) * X_W'(NUM_SETS);
  assign div_rem  = div_x - div_back;

  // Compare and byte select on the registered entry.
  assign shifted  = mem_q[sacrr_pkg::DATA_W-1:0] >> offset_r;
  assign tag_eq   = mem_q[ENT_W-1:sacrr_pkg::DATA_W] == tag_r;
  assign slot_vld = valid_r[slot];
  assign last_way = way_r == WAY_W'(NUM_WAYS - 1);

  // Store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[slot];
  end

  // Valid bits are set by every store write and cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_waddr] <= 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacrr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    line_r     <= line_nxt;
    offset_r   <= offset_nxt;
    value_r    <= value_nxt;
    victim_r   <= victim_nxt;
    set_r      <= set_nxt;
    tag_r      <= tag_nxt;
    way_r      <= way_nxt;
    rem_r      <= rem_nxt;
    qd_r       <= qd_nxt;
    cnt_r      <= cnt_nxt;
    res_hit_r  <= res_hit_nxt;
    res_byte_r <= res_byte_nxt;
    out_hit_r  <= out_hit_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // Sequencer: split the address, probe the ways in order, then post the result.
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    line_nxt      = line_r;
    offset_nxt    = offset_r;
    value_nxt     = value_r;
    victim_nxt    = victim_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    way_nxt       = way_r;
    rem_nxt       = rem_r;
    qd_nxt        = qd_r;
    cnt_nxt       = cnt_r;
    res_hit_nxt   = res_hit_r;
    res_byte_nxt  = res_byte_r;
    out_hit_nxt   = out_hit_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = slot;
    mem_wdata     = {tag_r, value_r};

    case (state_r)
      sacrr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          func_nxt     = in_func;
          line_nxt     = NUM_W'(in_addr[sacrr_pkg::ADDR_W-1:sacrr_pkg::OFFSET_BITS]);
          offset_nxt   = in_addr[sacrr_pkg::OFFSET_BITS-1:0];
          value_nxt    = in_write_value;
          victim_nxt   = WAY_W'(sacrr_pkg::victim_mod(in_victim_way, NUM_WAYS));
          way_nxt      = '0;
          rem_nxt      = '0;
          cnt_nxt      = '0;
          res_hit_nxt  = 1'b0;
          res_byte_nxt = '0;
          set_nxt      = SET_W'(in_addr[sacrr_pkg::ADDR_W-1:sacrr_pkg::OFFSET_BITS]
                                & LINE_W'(NUM_SETS - 1));
          tag_nxt      = TAG_W'(in_addr[sacrr_pkg::ADDR_W-1:sacrr_pkg::OFFSET_BITS]
                                >> SET_BITS);
          state_nxt    = SETS_POW2 ? sacrr_pkg::ST_READ : sacrr_pkg::ST_DIV;
        end
      end

      sacrr_pkg::ST_DIV: begin
        // Even steps form a quotient digit; odd steps take the remainder and
        // shift the digit into the line register from the bottom.
        cnt_nxt = cnt_r + 1'b1;
        if (!cnt_r[0]) begin
          qd_nxt = div_prod[MAG_S +: DIG_W];
        end else begin
          rem_nxt  = SET_W'(div_rem);
          line_nxt = {line_r[NUM_W-DIG_W-1:0], qd_r};
        end
        if (cnt_r == CNT_W'(2 * DIGITS - 1)) begin
          set_nxt   = SET_W'(div_rem);
          tag_nxt   = TAG_W'({line_r[NUM_W-DIG_W-1:0], qd_r});
          state_nxt = sacrr_pkg::ST_READ;
        end
      end

      sacrr_pkg::ST_READ: begin
        state_nxt = sacrr_pkg::ST_CMP;
      end

      sacrr_pkg::ST_CMP: begin
        if (func_r == sacrr_pkg::FUNC_READ) begin
          if (slot_vld && tag_eq) begin
            res_hit_nxt  = 1'b1;
            res_byte_nxt = shifted[sacrr_pkg::BYTE_W-1:0];
            state_nxt    = sacrr_pkg::ST_RESP;
          end else if (last_way) begin
            state_nxt = sacrr_pkg::ST_RESP;
          end else begin
            way_nxt   = way_r + 1'b1;
            state_nxt = sacrr_pkg::ST_READ;
          end
        end else begin
          if (!slot_vld) begin
            // An empty way takes the line.
            mem_we    = 1'b1;
            state_nxt = sacrr_pkg::ST_RESP;
          end else if (tag_eq) begin
            // A matching way is updated in place.
            mem_we      = 1'b1;
            res_hit_nxt = 1'b1;
            state_nxt   = sacrr_pkg::ST_RESP;
          end else if (last_way) begin
            // Full set with no match: replace the chosen victim.
            mem_we    = 1'b1;
            mem_waddr = victim_slot;
            state_nxt = sacrr_pkg::ST_RESP;
          end else begin
            way_nxt   = way_r + 1'b1;
            state_nxt = sacrr_pkg::ST_READ;
          end
        end
      end

      sacrr_pkg::ST_RESP: begin
        // Load the output register once the previous result has gone.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_byte_nxt  = res_byte_r;
          state_nxt     = sacrr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sacrr_pkg::ST_IDLE;
      end
    endcase
  end

  // A new result only appears after the response step.
  a_rise_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sacrr_pkg::ST_RESP))
    else $error("result posted outside the response step");

  // Writes and read misses never carry a byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_byte_r == '0)
    else $error("nonzero byte without a read hit");

  // The store is written only by a write access during compare.
  a_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == sacrr_pkg::ST_CMP && func_r == sacrr_pkg::FUNC_WRITE)
    else $error("store written outside a write compare");

  // The probe never runs past the last way.
  a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sacrr_pkg::ST_CMP |-> way_r <= WAY_W'(NUM_WAYS - 1))
    else $error("way counter out of range");

endmodule

>>> verif/set_assoc_cache_random_replace_tb.sv
module set_assoc_cache_random_replace_tb;

  localparam int unsigned ADDR_W      = sacrr_pkg::ADDR_W;
  localparam int unsigned DATA_W      = sacrr_pkg::DATA_W;
  localparam int unsigned BYTE_W      = sacrr_pkg::BYTE_W;
  localparam int unsigned VICTIM_W    = sacrr_pkg::VICTIM_W;
  localparam int unsigned OFFSET_BITS = sacrr_pkg::OFFSET_BITS;
  localparam logic        FUNC_WRITE  = sacrr_pkg::FUNC_WRITE;
  localparam logic        FUNC_READ   = sacrr_pkg::FUNC_READ;

  localparam int unsigned NUM_LINES = sacrr_pkg::DEF_NUM_LINES;
  localparam int unsigned NUM_WAYS  = sacrr_pkg::DEF_NUM_WAYS;
  localparam int unsigned NUM_SETS  = NUM_LINES / NUM_WAYS;
  localparam int unsigned SET_W     = $clog2(NUM_SETS);
  localparam int unsigned TAG_W     = ADDR_W - OFFSET_BITS - SET_W;

  localparam int unsigned RANDOM_ACCESSES = 620;
  localparam int unsigned PHASE_A_END     = 215;
  localparam int unsigned PHASE_B_END     = 430;
  localparam int unsigned HOLD_AT         = 500;
  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned SETTLE_CYCLES   = 2 * NUM_WAYS + 12;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic                drain_first;
    logic                func;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   value;
    logic [VICTIM_W-1:0] victim;
  } access_t;

  typedef struct packed {
    logic              hit;
    logic [BYTE_W-1:0] rbyte;
  } lookup_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_func        = FUNC_WRITE;
  logic [ADDR_W-1:0]   in_addr        = '0;
  logic [DATA_W-1:0]   in_write_value = '0;
  logic [VICTIM_W-1:0] in_victim_way  = '0;
  logic                out_stall      = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                out_hit;
  logic [BYTE_W-1:0]   out_read_byte;

  // Shadow copy of the cache contents, one entry per way.
  bit                  way_valid [NUM_LINES];
  logic [TAG_W-1:0]    way_tag   [NUM_LINES];
  logic [DATA_W-1:0]   way_word  [NUM_LINES];

  access_t     access_q [$];
  lookup_t     lookup_q [$];
  access_t     cur_access;
  int unsigned sent_cnt  = 0;
  int unsigned rcv_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt   = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  set_assoc_cache_random_replace i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_addr        (in_addr),
    .in_write_value (in_write_value),
    .in_victim_way  (in_victim_way),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_byte  (out_read_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Idle percentage for the current phase of the run.
  function automatic int unsigned idle_pct(int unsigned n, int unsigned first,
                                           int unsigned second);
    if (n < PHASE_A_END) begin
      return first;
    end else if (n < PHASE_B_END) begin
      return second;
    end
    return 0;
  endfunction

  function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tag,
                                                   logic [SET_W-1:0] set_idx,
                                                   logic [OFFSET_BITS-1:0] off);
    return {tag, set_idx, off};
  endfunction

  task automatic add_access(logic func, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value,
                            logic [VICTIM_W-1:0] victim, logic drain_first);
    access_t a;
    a.drain_first = drain_first;
    a.func        = func;
    a.addr        = addr;
    a.value       = value;
    a.victim      = victim;
    access_q.push_back(a);
  endtask

  task automatic report_mismatch(string what);
    $display("ERROR cycle %0d: %s", cycle_cnt, what);
    err_cnt++;
  endtask

  // Applies one access to the shadow cache and returns the lookup it produces.
  function automatic lookup_t cache_lookup(access_t a);
    lookup_t           r;
    int unsigned       base;
    int unsigned       slot;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] shifted;
    bit                done;
    r    = '0;
    done = 1'b0;
    tag  = a.addr[ADDR_W-1 -: TAG_W];
    base = a.addr[OFFSET_BITS +: SET_W] * NUM_WAYS;
    if (a.func == FUNC_WRITE) begin
      // The first empty way is filled; a matching valid way is updated.
      for (int w = 0; w < NUM_WAYS; w++) begin
        slot = base + w;
        if (!done && !way_valid[slot]) begin
          way_valid[slot] = 1'b1;
          way_tag[slot]   = tag;
          way_word[slot]  = a.value;
          done            = 1'b1;
        end else if (!done && way_tag[slot] == tag) begin
          way_word[slot] = a.value;
          r.hit          = 1'b1;
          done           = 1'b1;
        end
      end
      // A full set with no match loses the way that the victim code names.
      if (!done) begin
        slot            = base + (a.victim % NUM_WAYS);
        way_valid[slot] = 1'b1;
        way_tag[slot]   = tag;
        way_word[slot]  = a.value;
      end
    end else begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        slot = base + w;
        if (!done && way_valid[slot] && way_tag[slot] == tag) begin
          shifted = way_word[slot] >> a.addr[OFFSET_BITS-1:0];
          r.hit   = 1'b1;
          r.rbyte = shifted[BYTE_W-1:0];
          done    = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Driver: predicts each transfer and offers the next pending access.
  always @(posedge clk) begin : driver
    access_t nxt;
    bit      hold_back;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        lookup_q.push_back(cache_lookup(cur_access));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        hold_back = access_q.size() == 0;
        if (!hold_back && access_q[0].drain_first && lookup_q.size() != 0) begin
          hold_back = 1'b1;
        end
        if (!hold_back && $urandom_range(99) < idle_pct(sent_cnt, 34, 77)) begin
          hold_back = 1'b1;
        end
        if (hold_back) begin
          in_valid <= 1'b0;
        end else begin
          nxt = access_q.pop_front();
          cur_access     <= nxt;
          in_valid       <= 1'b1;
          in_func        <= nxt.func;
          in_addr        <= nxt.addr;
          in_write_value <= nxt.value;
          in_victim_way  <= nxt.victim;
        end
      end
    end
  end

  // Receiver stall: random per phase, plus one long hold to back up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < idle_pct(rcv_cnt, 77, 34);
    end
  end

  // Monitor: each result transfer is checked against the oldest expected lookup.
  always @(posedge clk) begin : monitor
    lookup_t want;
    if (rst_n && out_valid && !out_stall) begin
      rcv_cnt <= rcv_cnt + 1;
      if (lookup_q.size() == 0) begin
        report_mismatch("result transfer with no access outstanding");
      end else begin
        want = lookup_q.pop_front();
        if (out_hit !== want.hit) begin
          report_mismatch($sformatf("hit: got %b, want %b", out_hit, want.hit));
        end
        if (out_read_byte !== want.rbyte) begin
          report_mismatch($sformatf("read_byte: got %02h, want %02h",
                                    out_read_byte, want.rbyte));
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [TAG_W-1:0]       tag_pool [6];
    logic [SET_W-1:0]       set_pool [4];
    logic [TAG_W-1:0]       tag;
    logic [SET_W-1:0]       set_idx;
    logic [TAG_W-1:0]       t_a, t_b, t_c, t_d, t_e, t_f, t_g, t_h;
    logic [SET_W-1:0]       s5;

    t_a = '1;
    t_b = '0;
    t_c = {1'b1, {(TAG_W-1){1'b0}}};
    t_d = TAG_W'(1);
    t_e = {(TAG_W/2){2'b01}};
    t_f = {(TAG_W/2){2'b10}};
    t_g = TAG_W'(2);
    t_h = TAG_W'(3);
    s5  = SET_W'(5);

    // Empty cache, offsets at both ends, and an unaligned write that updates.
    add_access(FUNC_READ,  line_addr('0, '0, '0), '0, '0, 1'b0);
    add_access(FUNC_WRITE, line_addr('0, '0, '0), 64'h8877_6655_4433_2211, 2'd0, 1'b0);
    add_access(FUNC_READ,  line_addr('0, '0, '0), '0, '0, 1'b0);
    add_access(FUNC_READ,  line_addr('0, '0, 6'd63), '1, 2'd3, 1'b0);
    add_access(FUNC_WRITE, line_addr('0, '0, 6'd37), '1, 2'd3, 1'b0);
    add_access(FUNC_READ,  line_addr('0, '0, 6'd60), '0, '0, 1'b0);
    add_access(FUNC_WRITE, '1, '1, 2'd3, 1'b0);
    add_access(FUNC_READ,  '1, '0, '0, 1'b0);
    add_access(FUNC_READ,  line_addr('1, '1, '0), '0, '0, 1'b0);

    // Fill one set, then replace through each victim code.
    add_access(FUNC_WRITE, line_addr(t_a, s5, '0), 64'h0123_4567_89AB_CDEF, 2'd1, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_b, s5, '0), 64'hFEDC_BA98_7654_3210, 2'd2, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_c, s5, '0), 64'hA5A5_5A5A_C3C3_3C3C, 2'd0, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_d, s5, '0), '0, 2'd1, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_e, s5, 6'd17), 64'h0000_0000_0000_AB00, 2'd2, 1'b0);
    add_access(FUNC_READ,  line_addr(t_c, s5, '0), '0, '0, 1'b0);
    add_access(FUNC_READ,  line_addr(t_e, s5, 6'd8), '0, '0, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_f, s5, '0), 64'h1111_2222_3333_4444, 2'd0, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_g, s5, '0), 64'h5555_6666_7777_8888, 2'd1, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_h, s5, '0), 64'h9999_AAAA_BBBB_CCCC, 2'd3, 1'b0);
    add_access(FUNC_READ,  line_addr(t_d, s5, '0), '0, '0, 1'b0);
    add_access(FUNC_READ,  line_addr(t_h, s5, '0), '0, '0, 1'b0);
    add_access(FUNC_READ,  line_addr(t_a, s5, '0), '0, '0, 1'b0);
    add_access(FUNC_WRITE, line_addr(t_e, s5, 6'd63), '0, 2'd3, 1'b0);
    add_access(FUNC_READ,  line_addr(t_e, s5, 6'd5), '0, '0, 1'b0);

    // A few busy sets and a small tag pool keep hits and evictions frequent.
    foreach (tag_pool[i]) begin
      tag_pool[i] = TAG_W'({$urandom, $urandom});
    end
    foreach (set_pool[i]) begin
      set_pool[i] = SET_W'($urandom);
    end
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if ($urandom_range(99) < 80) begin
        set_idx = set_pool[$urandom_range(3)];
      end else begin
        set_idx = SET_W'($urandom);
      end
      if ($urandom_range(99) < 85) begin
        tag = tag_pool[$urandom_range(5)];
      end else begin
        tag = TAG_W'({$urandom, $urandom});
      end
      add_access(logic'($urandom_range(1)),
                 line_addr(tag, set_idx, OFFSET_BITS'($urandom)),
                 {$urandom, $urandom}, VICTIM_W'($urandom_range(3)),
                 i == 0 || i == 300);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every access to transfer and every lookup to return.
    while (access_q.size() != 0 || in_valid || lookup_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (lookup_q.size() != 0) begin
      report_mismatch($sformatf("%0d lookups never returned", lookup_q.size()));
    end

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sacrr_pkg.sv
sv/set_assoc_cache_random_replace.sv
verif/set_assoc_cache_random_replace_tb.sv
